// ===== rtl/hwd_pkg.sv =====
package hwd_pkg;

  localparam int ROW_MAX_DEF    = 2048;
  localparam int MAX_LEVELS_DEF = 3;
  localparam int FRAC_BITS      = 3;
  localparam int WORK_W         = 14;
  localparam int THR_W          = 11;
  localparam int BLK_W          = 9;
  localparam int LEV_W          = 2;
  localparam int QDEPTH         = 4;

  localparam logic [BLK_W-1:0] ROW_BLOCKS_RST = 9'd150;
  localparam logic [LEV_W-1:0] LEVELS_RST     = 2'd3;
  localparam logic [THR_W-1:0] THRESHOLD_RST  = 11'd120;

  typedef enum logic [1:0] {
    REG_ROW_BLOCKS = 2'd0,
    REG_LEVELS     = 2'd1,
    REG_THRESHOLD  = 2'd2
  } hwd_reg_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } hwd_op_e;

  typedef struct packed {
    hwd_op_e    op;
    logic [7:0] pixel;
  } hwd_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CALC,
    ST_WR2,
    ST_RDOUT
  } hwd_state_e;

  typedef enum logic [1:0] {
    PH_COPY,
    PH_FWD,
    PH_INV
  } hwd_phase_e;

  function automatic logic signed [WORK_W-1:0] shrink(
    input logic signed [WORK_W-1:0] d,
    input logic [THR_W-1:0] t
  );
    logic signed [WORK_W:0] dx;
    logic signed [WORK_W:0] tx;
    logic signed [WORK_W:0] m;
    logic signed [WORK_W:0] r;
    dx = {d[WORK_W-1], d};
    tx = signed'((WORK_W+1)'(t));
    m  = (dx < 0) ? -dx : dx;
    if (m <= tx) begin
      r = '0;
    end else if (dx > 0) begin
      r = dx - tx;
    end else begin
      r = dx + tx;
    end
    return r[WORK_W-1:0];
  endfunction

  function automatic logic [7:0] round_pix(input logic signed [WORK_W-1:0] v);
    logic signed [WORK_W:0] vx;
    logic signed [WORK_W:0] p;
    logic [7:0] r;
    vx = {v[WORK_W-1], v};
    if (vx < signed'((WORK_W+1)'(1 << (FRAC_BITS - 1)))) begin
      r = '0;
    end else begin
      p = (vx + signed'((WORK_W+1)'(1 << (FRAC_BITS - 1)))) >>> FRAC_BITS;
      if (p > signed'((WORK_W+1)'(255))) begin
        r = 8'hFF;
      end else begin
        r = p[7:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/hwd_front.sv =====
module hwd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              opcode_i,
  input  logic [7:0]        pixel_in_i,
  output logic              full_o,
  output logic              valid_o,
  output hwd_pkg::hwd_item_t item_o,
  input  logic              pop_i
);
  import hwd_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  hwd_item_t        fifo_q [QDEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;
  hwd_item_t        item_in;

  assign item_in.op    = hwd_op_e'(opcode_i);
  assign item_in.pixel = pixel_in_i;

  assign full_o  = (cnt_q == (PW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = fifo_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wp_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + PW'(1);
      if (do_pop)  rp_q <= rp_q + PW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/hwd_back.sv =====
module hwd_back #(
  parameter int ROW_MAX    = hwd_pkg::ROW_MAX_DEF,
  parameter int MAX_LEVELS = hwd_pkg::MAX_LEVELS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [hwd_pkg::BLK_W-1:0] row_blocks_i,
  input  logic [hwd_pkg::LEV_W-1:0] levels_i,
  input  logic [hwd_pkg::THR_W-1:0] threshold_i,
  input  logic                      q_valid_i,
  input  hwd_pkg::hwd_item_t        q_item_i,
  output logic                      q_pop_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [7:0]                pixel_out_o,
  output logic                      row_end_o,
  output logic                      ready_res_o
);
  import hwd_pkg::*;

  localparam int AW   = $clog2(ROW_MAX);
  localparam int KW   = AW - 1;
  localparam int LCW  = $clog2(ROW_MAX + 1);
  localparam int BW   = LCW - 3;
  localparam int BMAX = ROW_MAX / 8;

  logic [7:0]               load_mem [ROW_MAX];
  logic signed [WORK_W-1:0] work_mem [ROW_MAX];

  hwd_state_e               state_q, state_d;
  hwd_phase_e               phase_q;
  logic [LEV_W-1:0]         lev_q, lv_q;
  logic [KW-1:0]            k_q;
  logic                     last_q;
  logic [THR_W-1:0]         t_q;
  logic [LCW-1:0]           len_q, rp_q, lcnt_q;
  logic                     ovalid_q;
  logic signed [WORK_W-1:0] v1_q;
  logic [7:0]               ld0_q, ld1_q;
  logic signed [WORK_W-1:0] wk0_q, wk1_q;
  logic [AW-1:0]            wa0_q, wa1_q;
  logic                     out_valid_q, row_end_q, ready_q;
  logic [7:0]               pix_q;

  logic [BW-1:0]            bsat;
  logic [LCW-1:0]           n_cur;
  logic [LEV_W-1:0]         lv_cfg;
  logic                     take, complete, hit, final_pass, rd_last;
  logic [LCW-1:0]           kmax;
  logic [AW-1:0]            ra0, ra1, wk_ra0, wk_wa;
  logic                     wk_we, ld_we;
  logic signed [WORK_W-1:0] wk_wd;
  logic signed [WORK_W-1:0] x0, x1, v0, v1;
  logic signed [WORK_W:0]   sum, dif;
  logic                     use_load;

  always_comb begin
    if (row_blocks_i == '0) begin
      bsat = BW'(1);
    end else if (int'(row_blocks_i) > BMAX) begin
      bsat = BW'(BMAX);
    end else begin
      bsat = BW'(row_blocks_i);
    end
  end
  assign n_cur  = {bsat, 3'b000};
  assign lv_cfg = (int'(levels_i) > MAX_LEVELS) ? LEV_W'(MAX_LEVELS) : levels_i;

  assign take     = q_valid_i && (q_item_i.op == OP_LOAD || !out_valid_q);
  assign complete = ({1'b0, lcnt_q} + (LCW+1)'(1)) >= {1'b0, n_cur};
  assign hit      = ovalid_q && (rp_q < len_q);
  assign rd_last  = ({1'b0, rp_q} + (LCW+1)'(1)) >= {1'b0, len_q};
  assign final_pass = (phase_q == PH_COPY) || (phase_q == PH_INV && lev_q == '0);

  assign kmax = (len_q >> ({1'b0, lev_q} + 3'd1)) - LCW'(1);
  assign ra0  = AW'({k_q, 1'b0}) << lev_q;
  assign ra1  = ra0 + (AW'(1) << lev_q);

  // pair arithmetic
  assign use_load = (phase_q == PH_COPY) || (phase_q == PH_FWD && lev_q == '0);
  assign x0  = use_load ? signed'(WORK_W'(ld0_q) << FRAC_BITS) : wk0_q;
  assign x1  = use_load ? signed'(WORK_W'(ld1_q) << FRAC_BITS) : wk1_q;
  assign sum = {x0[WORK_W-1], x0} + {x1[WORK_W-1], x1};
  assign dif = {x0[WORK_W-1], x0} - {x1[WORK_W-1], x1};

  always_comb begin
    unique case (phase_q)
      PH_FWD: begin
        v0 = sum[WORK_W:1];
        v1 = shrink(dif[WORK_W:1], t_q);
      end
      PH_INV: begin
        v0 = sum[WORK_W-1:0];
        v1 = dif[WORK_W-1:0];
      end
      default: begin
        v0 = x0;
        v1 = x1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (q_item_i.op == OP_LOAD) begin
            if (complete) state_d = ST_PREP;
          end else if (hit) begin
            state_d = ST_RDOUT;
          end
        end
      end
      ST_PREP:  state_d = ST_CALC;
      ST_CALC:  state_d = ST_WR2;
      ST_WR2: begin
        if (!last_q) begin
          state_d = ST_CALC;
        end else if (final_pass) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_RDOUT: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o = 1'b0;
    ld_we   = 1'b0;
    wk_we   = 1'b0;
    wk_wa   = wa0_q;
    wk_wd   = v0;
    wk_ra0  = ra0;
    unique case (state_q)
      ST_IDLE: begin
        q_pop_o = take;
        ld_we   = take && (q_item_i.op == OP_LOAD);
        wk_ra0  = rp_q[AW-1:0];
      end
      ST_CALC: begin
        wk_we = 1'b1;
      end
      ST_WR2: begin
        wk_we = 1'b1;
        wk_wa = wa1_q;
        wk_wd = v1_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      load_mem[lcnt_q[AW-1:0]] <= q_item_i.pixel;
    end
    ld0_q <= load_mem[ra0];
    ld1_q <= load_mem[ra1];
  end

  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      work_mem[wk_wa] <= wk_wd;
    end
    wk0_q <= work_mem[wk_ra0];
    wk1_q <= work_mem[ra1];
    wa0_q <= ra0;
    wa1_q <= ra1;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      v1_q <= v1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_COPY;
      lev_q       <= '0;
      lv_q        <= '0;
      k_q         <= '0;
      last_q      <= 1'b0;
      t_q         <= '0;
      len_q       <= '0;
      rp_q        <= '0;
      lcnt_q      <= '0;
      ovalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pix_q       <= '0;
      row_end_q   <= 1'b0;
      ready_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take && q_item_i.op == OP_LOAD) begin
            if (complete) begin
              lcnt_q   <= '0;
              len_q    <= n_cur;
              rp_q     <= '0;
              ovalid_q <= 1'b0;
              lv_q     <= lv_cfg;
              t_q      <= threshold_i;
              lev_q    <= '0;
              k_q      <= '0;
              phase_q  <= (lv_cfg == '0) ? PH_COPY : PH_FWD;
            end else begin
              lcnt_q <= lcnt_q + LCW'(1);
            end
          end else if (take && !hit) begin
            ovalid_q    <= 1'b0;
            out_valid_q <= 1'b1;
            pix_q       <= '0;
            row_end_q   <= 1'b0;
            ready_q     <= 1'b0;
          end
        end
        ST_CALC: begin
          last_q <= (k_q == kmax[KW-1:0]);
          if (k_q != kmax[KW-1:0]) k_q <= k_q + KW'(1);
        end
        ST_WR2: begin
          if (last_q) begin
            k_q <= '0;
            if (final_pass) begin
              ovalid_q <= 1'b1;
            end else if (phase_q == PH_FWD) begin
              if (lev_q == lv_q - LEV_W'(1)) begin
                phase_q <= PH_INV;
              end else begin
                lev_q <= lev_q + LEV_W'(1);
              end
            end else begin
              lev_q <= lev_q - LEV_W'(1);
            end
          end
        end
        ST_RDOUT: begin
          out_valid_q <= 1'b1;
          pix_q       <= round_pix(wk0_q);
          row_end_q   <= rd_last;
          ready_q     <= 1'b1;
          rp_q        <= rp_q + LCW'(1);
          if (rd_last) ovalid_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign empty_o     = !out_valid_q;
  assign pixel_out_o = pix_q;
  assign row_end_o   = row_end_q;
  assign ready_res_o = ready_q;

endmodule

// ===== rtl/haar_wavelet_row_denoiser_core.sv =====
// Load item: written into the load memory; the row's last load starts the transform.
// Transform: each pass runs ST_PREP, then ST_CALC and ST_WR2 for each pixel pair, while
// reads wait. Read item: taken only while the output is empty; a hit is registered
// after ST_RDOUT, a miss directly as a zero item with ready_res low.
// Reset (async, active low) empties queue and output, clears counters and
// restores registers; the pixel memories are not cleared.
module haar_wavelet_row_denoiser_core #(
  parameter int ROW_MAX    = hwd_pkg::ROW_MAX_DEF,
  parameter int MAX_LEVELS = hwd_pkg::MAX_LEVELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic [7:0]  pixel_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  pixel_out_o,
  output logic        row_end_o,
  output logic        ready_res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hwd_pkg::*;

  logic [BLK_W-1:0] row_blocks_q;
  logic [LEV_W-1:0] levels_q;
  logic [THR_W-1:0] threshold_q;
  logic             cfg_we;
  hwd_reg_e         reg_sel;
  logic             q_valid, q_pop;
  hwd_item_t        q_item;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = hwd_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_blocks_q <= ROW_BLOCKS_RST;
      levels_q     <= LEVELS_RST;
      threshold_q  <= THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_ROW_BLOCKS: row_blocks_q <= pwdata[BLK_W-1:0];
        REG_LEVELS:     levels_q     <= pwdata[LEV_W-1:0];
        REG_THRESHOLD:  threshold_q  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROW_BLOCKS: prdata = 32'(row_blocks_q);
      REG_LEVELS:     prdata = 32'(levels_q);
      REG_THRESHOLD:  prdata = 32'(threshold_q);
      default:        prdata = '0;
    endcase
  end

  hwd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .opcode_i   (opcode_i),
    .pixel_in_i (pixel_in_i),
    .full_o     (full),
    .valid_o    (q_valid),
    .item_o     (q_item),
    .pop_i      (q_pop)
  );

  hwd_back #(
    .ROW_MAX    (ROW_MAX),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_blocks_i (row_blocks_q),
    .levels_i     (levels_q),
    .threshold_i  (threshold_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .pixel_out_o  (pixel_out_o),
    .row_end_o    (row_end_o),
    .ready_res_o  (ready_res_o)
  );

endmodule

// ===== rtl/hwd_checker.sv =====
module hwd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] pixel_out_o,
  input logic       row_end_o,
  input logic       ready_res_o,
  input logic       pready
);

  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pixel_out_o) && $stable(row_end_o)
                          && $stable(ready_res_o)))
    else $error("waiting item changed");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !ready_res_o) |-> (pixel_out_o == 8'd0 && !row_end_o))
    else $error("miss item carries data");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind haar_wavelet_row_denoiser_core hwd_checker u_hwd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .pixel_out_o (pixel_out_o),
  .row_end_o   (row_end_o),
  .ready_res_o (ready_res_o),
  .pready      (pready)
);

// ===== dv/hwd_row_scoreboard.sv =====
`timescale 1ns / 100ps

module hwd_row_scoreboard
  import hwd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic        opcode_i,
  input  logic [7:0]  pixel_in_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  pixel_out_o,
  input  logic        row_end_o,
  input  logic        ready_res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count_o,
  output int          pending_o,
  output int          pixels_seen_o,
  output int          rows_done_o
);

  localparam int ROW_MAX = ROW_MAX_DEF;

  typedef struct {
    logic [7:0] pixel;
    logic       row_end;
    logic       ready;
  } pix_result_t;

  pix_result_t pix_q[$];

  logic [BLK_W-1:0] cfg_blocks;
  logic [LEV_W-1:0] cfg_levels;
  logic [THR_W-1:0] cfg_thr;

  logic [7:0] raw_row[ROW_MAX];
  int         coef[ROW_MAX];
  int         tmp[ROW_MAX];
  int         load_cnt;
  int         rd_ptr;
  int         out_n;
  bit         out_ok;

  assign pending_o = pix_q.size();

  function automatic int row_len();
    int b;
    b = cfg_blocks;
    if (b == 0) b = 1;
    if (b > ROW_MAX / 8) b = ROW_MAX / 8;
    return b * 8;
  endfunction

  function automatic int soft_thr(int d, int t);
    int m;
    m = (d < 0) ? -d : d;
    if (m <= t) return 0;
    return (d > 0) ? d - t : d + t;
  endfunction

  function automatic void denoise_row(int n);
    int lv;
    int half;
    int v;
    lv = (cfg_levels > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : cfg_levels;
    for (int i = 0; i < n; i++) coef[i] = raw_row[i] * 8;
    for (int l = 0; l < lv; l++) begin
      half = n >> (l + 1);
      for (int i = 0; i < half; i++) begin
        tmp[i]        = (coef[2*i] + coef[2*i+1]) / 2;
        tmp[half + i] = (coef[2*i] - coef[2*i+1]) / 2;
      end
      for (int i = 0; i < 2 * half; i++) coef[i] = tmp[i];
    end
    for (int l = 0; l < lv; l++)
      for (int i = n >> (l + 1); i < (n >> l); i++) coef[i] = soft_thr(coef[i], int'(cfg_thr));
    for (int l = lv; l > 0; l--) begin
      half = n >> l;
      for (int i = 0; i < half; i++) begin
        tmp[2*i]   = coef[i] + coef[half + i];
        tmp[2*i+1] = coef[i] - coef[half + i];
      end
      for (int i = 0; i < 2 * half; i++) coef[i] = tmp[i];
    end
    for (int i = 0; i < n; i++) begin
      v = coef[i];
      if (v < 4) begin
        coef[i] = 0;
      end else begin
        v = (v + 4) >>> 3;
        coef[i] = (v > 255) ? 255 : v;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_result_t want;
    pix_result_t got;
    int n;
    if (!rst_ni) begin
      pix_q.delete();
      cfg_blocks    = ROW_BLOCKS_RST;
      cfg_levels    = LEVELS_RST;
      cfg_thr       = THRESHOLD_RST;
      load_cnt      = 0;
      rd_ptr        = 0;
      out_n         = 0;
      out_ok        = 0;
      fail_count_o  = 0;
      pixels_seen_o = 0;
      rows_done_o   = 0;
    end else begin
      if (pop && !empty) begin
        got.pixel   = pixel_out_o;
        got.row_end = row_end_o;
        got.ready   = ready_res_o;
        pixels_seen_o++;
        if (pix_q.size() == 0) begin
          $display("[%0t] MISMATCH unexpected result item", $time);
          fail_count_o++;
        end else begin
          want = pix_q.pop_front();
          if (got.pixel !== want.pixel) report_mismatch("pixel_out", got.pixel, want.pixel);
          if (got.row_end !== want.row_end)
            report_mismatch("row_end", got.row_end, want.row_end);
          if (got.ready !== want.ready) report_mismatch("ready_res", got.ready, want.ready);
        end
      end
      if (push && !full) begin
        if (hwd_op_e'(opcode_i) == OP_LOAD) begin
          n = row_len();
          if (load_cnt < ROW_MAX) raw_row[load_cnt] = pixel_in_i;
          load_cnt++;
          if (load_cnt >= n) begin
            denoise_row(n);
            out_n    = n;
            rd_ptr   = 0;
            out_ok   = 1;
            load_cnt = 0;
            rows_done_o++;
          end
        end else if (out_ok && rd_ptr < out_n) begin
          want.pixel   = coef[rd_ptr][7:0];
          want.row_end = (rd_ptr + 1 >= out_n);
          want.ready   = 1'b1;
          rd_ptr++;
          if (want.row_end) out_ok = 0;
          pix_q = {pix_q, want};
        end else begin
          out_ok = 0;
          want.pixel   = '0;
          want.row_end = 1'b0;
          want.ready   = 1'b0;
          pix_q = {pix_q, want};
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (hwd_reg_e'(paddr[3:2]))
          REG_ROW_BLOCKS: cfg_blocks = pwdata[BLK_W-1:0];
          REG_LEVELS:     cfg_levels = pwdata[LEV_W-1:0];
          REG_THRESHOLD:  cfg_thr    = pwdata[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== dv/haar_wavelet_row_denoiser_core_tb.sv =====
`timescale 1ns / 100ps

module haar_wavelet_row_denoiser_core_tb;
  import hwd_pkg::*;

  localparam int IDLE_LIMIT = 60000;
  localparam int SETTLE     = 8500;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        push       = 1'b0;
  logic        opcode_i   = 1'b0;
  logic [7:0]  pixel_in_i = '0;
  logic        pop        = 1'b0;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [3:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic        full;
  logic        empty;
  logic [7:0]  pixel_out_o;
  logic        row_end_o;
  logic        ready_res_o;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int pixels_seen;
  int rows_done;
  int idle_cycles;
  bit burst;
  int row_n;

  haar_wavelet_row_denoiser_core DUT (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .pixel_in_i, .empty, .pop,
    .pixel_out_o, .row_end_o, .ready_res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hwd_row_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .pixel_in_i, .empty, .pop,
    .pixel_out_o, .row_end_o, .ready_res_o,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending),
    .pixels_seen_o(pixels_seen), .rows_done_o(rows_done)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stall per item, pop held high while waiting
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  task automatic apb_write(hwd_reg_e r, int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(int rb, int lv, int thr);
    int b;
    apb_write(REG_ROW_BLOCKS, rb);
    apb_write(REG_LEVELS, lv);
    apb_write(REG_THRESHOLD, thr);
    b = rb % 512;
    if (b == 0) b = 1;
    if (b > 256) b = 256;
    row_n = b * 8;
  endtask

  task automatic send_item(hwd_op_e op, logic [7:0] pix);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    opcode_i   <= op;
    pixel_in_i <= pix;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic settle();
    if (push) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // mode 0 noise, 1 smooth with small ripple, 2 extremes, 3 flat
  task automatic send_row(int n, int mode);
    int base;
    int v;
    base = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = $urandom_range(0, 255);
        1: v = base + $urandom_range(0, 24) - 12 + i % 5;
        2: v = $urandom_range(0, 1) ? 255 : 0;
        default: v = base;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      send_item(OP_LOAD, v[7:0]);
    end
  endtask

  task automatic read_pixels(int k);
    for (int i = 0; i < k; i++) send_item(OP_READ, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_phase(int rows);
    int sel;
    for (int r = 0; r < rows; r++) begin
      if ($urandom_range(0, 9) == 0) read_pixels(1);
      send_row(row_n, $urandom_range(0, 3));
      sel = $urandom_range(0, 9);
      if (sel < 7) read_pixels(row_n);
      else if (sel < 9) read_pixels(row_n + $urandom_range(1, 2));
      else read_pixels($urandom_range(0, row_n - 1));
    end
  endtask

  initial begin
    int thr;
    burst = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing ready, then a short row with extremes, one read past the end
    set_config(1, 3, 0);
    send_item(OP_READ, 8'hFF);
    send_item(OP_LOAD, 8'd0);
    send_item(OP_LOAD, 8'd255);
    send_item(OP_LOAD, 8'd255);
    send_item(OP_LOAD, 8'd0);
    send_item(OP_LOAD, 8'd170);
    send_item(OP_LOAD, 8'd85);
    send_item(OP_LOAD, 8'd1);
    send_item(OP_LOAD, 8'd254);
    read_pixels(9);
    settle();

    set_config(1, 0, 2047);
    random_phase(2);
    settle();
    set_config(0, 3, 2047);
    random_phase(2);
    settle();

    // row length lowered mid-row
    set_config(4, 2, 40);
    send_row(20, 0);
    settle();
    apb_write(REG_ROW_BLOCKS, 1);
    row_n = 8;
    send_row(1, 0);
    read_pixels(8);
    settle();

    // config changed while draining, then a new row over unread output
    set_config(2, 3, 16);
    send_row(16, 1);
    read_pixels(5);
    settle();
    set_config(1, 0, 0);
    read_pixels(5);
    send_row(8, 0);
    read_pixels(10);
    settle();

    set_config(24, 3, 120);
    send_row(row_n, 1);
    read_pixels(16);
    settle();
    burst = 1;
    set_config(12, 2, 60);
    send_row(row_n, 0);
    read_pixels(row_n);
    settle();
    burst = 0;

    for (int p = 0; p < 4; p++) begin
      burst = (p % 4 == 3);
      thr = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, 200);
      set_config($urandom_range(1, 4), $urandom_range(0, 3), thr);
      random_phase($urandom_range(2, 4));
      settle();
    end
    burst = 0;

    $display("Covered %0d completed rows and %0d result items across row lengths 8..192,",
             rows_done, pixels_seen);
    $display("zero to three levels and thresholds from 0 to 2047.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
